// ===== rtl/min_max_selection_sort_engine_macros.svh =====
// assertion macros for the selection sort engine
// expects clk and rst_n in the scope of the module that uses them
`ifndef MIN_MAX_SELECTION_SORT_ENGINE_MACROS_SVH
`define MIN_MAX_SELECTION_SORT_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MMSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MMSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mmss_pkg.sv =====
// shared constants and the sequencer state type of the selection sort engine
// no dependencies
package mmss_pkg;

  localparam int DATA_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWAP_MAX_A,
    ST_SWAP_MAX_B,
    ST_SWAP_MIN_A,
    ST_SWAP_MIN_B,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/mmss_if.sv =====
// valid/ready stream interfaces for the input and result channels
// depends on mmss_pkg for the data width
interface mmss_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [mmss_pkg::DATA_W-1:0] value;
  logic                              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mmss_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mmss_pkg::DATA_W-1:0] sorted_value;
  logic                              end_of_set;
  logic                              truncated;

  modport source (output valid, output sorted_value, output end_of_set, output truncated,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_set, input truncated,
                  output ready);
endinterface

// ===== rtl/mmss_ram.sv =====
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
module mmss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/min_max_selection_sort_engine.sv =====
// top level of the double-ended selection sort engine: store, sequencer, output register
// depends on mmss_pkg, mmss_if, mmss_ram and the macros header
//
//  port    dir  beat carries                          notes
//  in_ch   in   value, last                           taken only while loading
//  out_ch  out  sorted_value, end_of_set, truncated   registered, held until taken
//
// loading takes one beat per cycle; a set ends on the beat with last set
// each pass scans the range lo..hi through the ram read port and then makes four
// writes for the two swaps, all through the single ram write port
// results are fetched one at a time, each only after the one before has landed;
// a stalled output simply holds the sequencer
// reset clears the state, the count and the flags only; the store needs no clearing pass
`include "min_max_selection_sort_engine_macros.svh"

module min_max_selection_sort_engine #(
  parameter int MAX_ELEMENTS = mmss_pkg::MAX_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  mmss_in_if.sink            in_ch,
  mmss_out_if.source         out_ch
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int DW = mmss_pkg::DATA_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

  mmss_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          rv_r, rv_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;
  logic signed [DW-1:0] min_r, min_nxt;
  logic signed [DW-1:0] max_r, max_nxt;
  logic signed [DW-1:0] vlo_r, vlo_nxt;
  logic signed [DW-1:0] vhi_r, vhi_nxt;
  logic [AW-1:0] pmin_r, pmin_nxt;
  logic [AW-1:0] pmax_r, pmax_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_val_r, out_val_nxt;
  logic                 out_eos_r, out_eos_nxt;
  logic                 out_trunc_r, out_trunc_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;
  logic signed [DW-1:0] rd_s;
  logic [CW-1:0] n_new;
  logic          eos;

  mmss_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_s          = $signed(rdata);
  assign in_ch.ready   = (state_r == mmss_pkg::ST_LOAD);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.end_of_set   = out_eos_r;
  assign out_ch.truncated    = out_trunc_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    iss_nxt       = iss_r;
    k_nxt         = k_r;
    ridx_nxt      = ridx_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    vlo_nxt       = vlo_r;
    vhi_nxt       = vhi_r;
    pmin_nxt      = pmin_r;
    pmax_nxt      = pmax_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_eos_nxt   = out_eos_r;
    out_trunc_nxt = out_trunc_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = iss_r[AW-1:0];
    n_new         = cnt_r;
    eos           = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mmss_pkg::ST_LOAD: begin
        if (in_ch.valid) begin
          if (cnt_r < MAX_C) begin
            we    = 1'b1;
            waddr = cnt_r[AW-1:0];
            wdata = in_ch.value;
            n_new = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          cnt_nxt = n_new;
          if (in_ch.last) begin
            lo_nxt  = '0;
            hi_nxt  = AW'(n_new - CW'(1));
            iss_nxt = '0;
            k_nxt   = '0;
            state_nxt = (n_new < CW'(2)) ? mmss_pkg::ST_EMIT : mmss_pkg::ST_SCAN;
          end
        end
      end

      mmss_pkg::ST_SCAN: begin
        if (iss_r <= CW'(hi_r)) begin
          re      = 1'b1;
          iss_nxt = iss_r + CW'(1);
        end
        if (rv_r) begin
          // first beat of the range seeds both extremes
          if (ridx_r == lo_r) begin
            min_nxt  = rd_s;
            max_nxt  = rd_s;
            vlo_nxt  = rd_s;
            pmin_nxt = ridx_r;
            pmax_nxt = ridx_r;
          end else begin
            if (rd_s < min_r) begin
              min_nxt  = rd_s;
              pmin_nxt = ridx_r;
            end
            if (max_r < rd_s) begin
              max_nxt  = rd_s;
              pmax_nxt = ridx_r;
            end
          end
          if (ridx_r == hi_r) begin
            vhi_nxt   = rd_s;
            state_nxt = mmss_pkg::ST_SWAP_MAX_A;
          end
        end
      end

      mmss_pkg::ST_SWAP_MAX_A: begin
        we        = 1'b1;
        waddr     = pmax_r;
        wdata     = vhi_r;
        state_nxt = mmss_pkg::ST_SWAP_MAX_B;
      end

      mmss_pkg::ST_SWAP_MAX_B: begin
        we        = 1'b1;
        waddr     = hi_r;
        wdata     = max_r;
        state_nxt = mmss_pkg::ST_SWAP_MIN_A;
      end

      mmss_pkg::ST_SWAP_MIN_A: begin
        // a minimum at the right end was moved to the old max slot;
        // the left end holds the old right value if the max sat there
        we        = 1'b1;
        waddr     = (pmin_r == hi_r) ? pmax_r : pmin_r;
        wdata     = (pmax_r == lo_r) ? vhi_r : vlo_r;
        state_nxt = mmss_pkg::ST_SWAP_MIN_B;
      end

      mmss_pkg::ST_SWAP_MIN_B: begin
        we      = 1'b1;
        waddr   = lo_r;
        wdata   = min_r;
        lo_nxt  = lo_r + AW'(1);
        hi_nxt  = hi_r - AW'(1);
        iss_nxt = CW'(lo_r) + CW'(1);
        if ((CW'(lo_r) + CW'(2)) < CW'(hi_r)) begin
          state_nxt = mmss_pkg::ST_SCAN;
        end else begin
          state_nxt = mmss_pkg::ST_EMIT;
        end
      end

      mmss_pkg::ST_EMIT: begin
        raddr = k_r[AW-1:0];
        // fetch only when the output register is free by the time data lands
        if (!rv_r && (!out_valid_r || out_ch.ready) && (k_r < cnt_r)) begin
          re    = 1'b1;
          k_nxt = k_r + CW'(1);
        end
        if (rv_r) begin
          eos           = ((CW'(ridx_r) + CW'(1)) == cnt_r);
          out_valid_nxt = 1'b1;
          out_val_nxt   = rd_s;
          out_eos_nxt   = eos;
          out_trunc_nxt = ovf_r;
          if (eos) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = mmss_pkg::ST_LOAD;
          end
        end
      end

      default: begin
        state_nxt = mmss_pkg::ST_LOAD;
      end
    endcase

    rv_nxt = re;
    if (re) begin
      ridx_nxt = raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmss_pkg::ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    iss_r       <= iss_nxt;
    k_r         <= k_nxt;
    ridx_r      <= ridx_nxt;
    min_r       <= min_nxt;
    max_r       <= max_nxt;
    vlo_r       <= vlo_nxt;
    vhi_r       <= vhi_nxt;
    pmin_r      <= pmin_nxt;
    pmax_r      <= pmax_nxt;
    out_val_r   <= out_val_nxt;
    out_eos_r   <= out_eos_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  // store access and sequencing checks
  `MMSS_ASSERT_IMP(a_no_rw_overlap, we, !re, "store read and write in the same cycle")
  `MMSS_ASSERT_IMP(a_load_no_read, state_r == mmss_pkg::ST_LOAD, !rv_r,
                   "read data pending while loading")
  `MMSS_ASSERT_IMP(a_emit_slot_free, rv_r && (state_r == mmss_pkg::ST_EMIT), !out_valid_r,
                   "result beat landed on an occupied output register")
  `MMSS_ASSERT_IMP(a_scan_range, state_r == mmss_pkg::ST_SCAN, lo_r < hi_r,
                   "scan with an empty range")
  `MMSS_ASSERT_NXT(a_count_cap, in_ch.valid && in_ch.ready, cnt_r <= MAX_C,
                   "element count beyond capacity")

endmodule
